// ----- hw/rtl/teoq_pkg.sv -----
package teoq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int TYPE_W = 8;
  localparam int ID_W   = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SPARE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
    logic [TYPE_W-1:0] typ;
    logic [ID_W-1:0]   id;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t ent;
  } cmd_t;

endpackage

// ----- hw/rtl/teoq_cell.sv -----
module teoq_cell
  import teoq_pkg::*;
(
  input  logic   clk,
  input  cmd_t   cmd,
  input  logic   occ,
  input  entry_t left_ent,
  input  logic   left_mark,
  input  logic   left_hit,
  input  entry_t right_ent,
  output entry_t ent,
  output logic   mark,
  output logic   hit
);

  entry_t ent_next;
  logic   later;
  logic   match;

  // stored time strictly later than the new item
  assign later = occ && ((ent.sec > cmd.ent.sec) ||
                         ((ent.sec == cmd.ent.sec) && (ent.usec > cmd.ent.usec)));
  // insert point lies here or to the left once mark is set
  assign mark  = !occ || later;

  // remove: first matching cell and all to its right shift left
  assign match = occ && (ent.typ == cmd.ent.typ) && (ent.id == cmd.ent.id);
  assign hit   = match || left_hit;

  // next entry
  always_comb begin
    ent_next = ent;
    priority if (cmd.ins) begin
      if (left_mark) begin
        ent_next = left_ent;
      end else if (mark) begin
        ent_next = cmd.ent;
      end
    end else if (cmd.rem) begin
      if (hit) begin
        ent_next = right_ent;
      end
    end else begin
      ent_next = ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ----- hw/rtl/time_ordered_event_queue.sv -----
// result strobe (done) follows the accepting edge through the EXEC state and the done register, one cycle wide
// a new item is accepted only while idle, once the cell chain has finished its update
// inserts and removes update all cells together in the EXEC state; the receiver cannot stall results
// reset (rst, synchronous): entry count cleared, idle, no strobe; slot contents unchanged
module time_ordered_event_queue
  import teoq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [SEC_W-1:0]     event_time_sec,
  input  logic [USEC_W-1:0]    event_time_usec,
  input  logic [TYPE_W-1:0]    event_type,
  input  logic [ID_W-1:0]      event_id,
  output logic                 done,
  output logic [1:0]           status,
  output logic                 head_valid,
  output logic [SEC_W-1:0]     head_time_sec,
  output logic [USEC_W-1:0]    head_time_usec,
  output logic [TYPE_W-1:0]    head_type,
  output logic [ID_W-1:0]      head_id,
  output logic [OUT_CNT_W-1:0] entry_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  mode_t             op_mode;
  entry_t            op_ent;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  status_t           status_next;
  status_t           status_r;
  logic              full;
  logic              found;
  cmd_t              cmd;
  logic              accept;

  entry_t                 cell_ent  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_mark;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  assign accept = start && !busy;
  assign busy   = (state == S_EXEC);

  // command register
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode_t'(mode);
      op_ent  <= '{sec: event_time_sec, usec: event_time_usec,
                   typ: event_type, id: event_id};
    end
  end

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign found = cell_hit[QUEUE_DEPTH-1];

  // broadcast to the cells during the update cycle
  always_comb begin
    cmd.ent = op_ent;
    cmd.ins = busy && (op_mode == MODE_INSERT) && !full;
    cmd.rem = busy && (op_mode == MODE_REMOVE);
  end

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      teoq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ent  (op_ent),
        .left_mark (1'b0),
        .left_hit  (1'b0),
        .right_ent (cell_ent[(i + 1) % QUEUE_DEPTH]),
        .ent       (cell_ent[i]),
        .mark      (cell_mark[i]),
        .hit       (cell_hit[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_last
      teoq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ent  (cell_ent[i-1]),
        .left_mark (cell_mark[i-1]),
        .left_hit  (cell_hit[i-1]),
        .right_ent (cell_ent[i]),
        .ent       (cell_ent[i]),
        .mark      (cell_mark[i]),
        .hit       (cell_hit[i])
      );
    end else begin : g_mid
      teoq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (cell_occ[i]),
        .left_ent  (cell_ent[i-1]),
        .left_mark (cell_mark[i-1]),
        .left_hit  (cell_hit[i-1]),
        .right_ent (cell_ent[i+1]),
        .ent       (cell_ent[i]),
        .mark      (cell_mark[i]),
        .hit       (cell_hit[i])
      );
    end
  end

  // count and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    unique case (op_mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      MODE_PEEK, MODE_SPARE: begin
        status_next = ST_OK;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= busy;
      if (busy) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      status_r <= status_next;
    end
  end

  // result from the head cell
  assign status         = status_r;
  assign head_valid     = (count != '0);
  assign head_time_sec  = head_valid ? cell_ent[0].sec  : '0;
  assign head_time_usec = head_valid ? cell_ent[0].usec : '0;
  assign head_type      = head_valid ? cell_ent[0].typ  : '0;
  assign head_id        = head_valid ? cell_ent[0].id   : '0;
  assign entry_count    = OUT_CNT_W'(count);

endmodule

// ----- hw/rtl/teoq_checker.sv -----
module teoq_checker
  import teoq_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [1:0]           status,
  input logic                 head_valid,
  input logic [OUT_CNT_W-1:0] entry_count
);

  // accepted item starts the update cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // update cycle is followed by exactly one result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("result strobe missing after update");

  // no result without an item in flight
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("unexpected result strobe");

  // head flag agrees with count
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    done |-> head_valid == (entry_count != '0))
    else $error("head_valid disagrees with entry_count");

  // a dropped insert only happens on a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> entry_count == OUT_CNT_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

endmodule

bind time_ordered_event_queue teoq_checker u_teoq_checker (.*);
